/* rtl/nlcs_pkg.sv */
package nlcs_pkg;

	localparam int COUNT_WIDTH_DEF = 32;
	localparam int QUEUE_DEPTH     = 4;
	localparam int OUT_BITS        = 136;

	localparam logic [7:0] BYTE_CR = 8'h0D;
	localparam logic [7:0] BYTE_LF = 8'h0A;

	typedef enum logic [1:0] {
		KIND_LF   = 2'd0,
		KIND_CRLF = 2'd1,
		KIND_CR   = 2'd2
	} kind_t;

	// What one byte contributes: up to two line endings, the second always a lone CR
	// (a held CR flushed by a CR that is itself the final byte).
	typedef struct packed {
		logic  k0_valid;
		kind_t k0_kind;
		logic  k1_valid;
		logic  last;
	} ending_evt_t;

endpackage

/* rtl/nlcs_front.sv */
module nlcs_front import nlcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	input  logic        q_full,
	output logic        in_ready,
	output logic        push,
	output ending_evt_t push_evt
);

	logic pend_q;
	logic pend_d;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		push_evt          = '0;
		push_evt.k0_kind  = KIND_LF;
		push_evt.last     = in_last;
		pend_d            = 1'b0;
		if (pend_q) begin
			push_evt.k0_valid = 1'b1;
			if (in_byte == BYTE_LF) begin
				push_evt.k0_kind = KIND_CRLF;
			end else begin
				push_evt.k0_kind = KIND_CR;
				pend_d           = (in_byte == BYTE_CR);
			end
		end else if (in_byte == BYTE_LF) begin
			push_evt.k0_valid = 1'b1;
			push_evt.k0_kind  = KIND_LF;
		end else if (in_byte == BYTE_CR) begin
			pend_d = 1'b1;
		end
		// A CR still held on the final byte closes as a lone CR.
		if (in_last && pend_d) begin
			pend_d = 1'b0;
			if (push_evt.k0_valid) begin
				push_evt.k1_valid = 1'b1;
			end else begin
				push_evt.k0_valid = 1'b1;
				push_evt.k0_kind  = KIND_CR;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (push) begin
			pend_q <= pend_d;
		end
	end

	a_no_pend_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		push && in_last |=> !pend_q)
		else $error("held CR survived the end of a stream");

endmodule

/* rtl/nlcs_queue.sv */
module nlcs_queue import nlcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  ending_evt_t push_evt,
	input  logic        pop,
	output logic        full,
	output logic        head_valid,
	output ending_evt_t head_evt
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	ending_evt_t    mem_q [QUEUE_DEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;

	assign full       = (cnt_q == CW'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_evt   = mem_q[rd_q];

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_evt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ptr_next(wr_q);
			end
			if (pop) begin
				rd_q <= ptr_next(rd_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		full && !pop |=> $stable(wr_q))
		else $error("event queue written while full");

endmodule

/* rtl/nlcs_back.sv */
module nlcs_back import nlcs_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                ev_valid,
	input  ending_evt_t         ev,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [OUT_BITS-1:0] out_data
);

	localparam int W = COUNT_WIDTH;

	logic [W-1:0] crlf_q, lf_q, cr_q, end_q, mline_q;
	kind_t        first_q;
	logic         seen_q, mixed_q;

	logic [W-1:0] crlf_d, lf_d, cr_d, end_d, mline_d;
	kind_t        first_d;
	logic         seen_d, mixed_d;

	logic [W-1:0] crlf_s1, lf_s1, cr_s1, mline_s1;
	logic         seen_s1, mixed_s1, valid_s1;

	logic                out_valid_q;
	logic [OUT_BITS-1:0] out_data_q;

	logic  out_load, s1_free;
	kind_t dom;

	function automatic logic [W-1:0] sat_add(input logic [W-1:0] v, input logic [1:0] inc);
		logic [W:0] s;
		s = {1'b0, v} + (W+1)'(inc);
		return s[W] ? '1 : s[W-1:0];
	endfunction

	function automatic logic [31:0] clamp32(input logic [W-1:0] v);
		logic [63:0] e;
		e = 64'(v);
		return (e > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : e[31:0];
	endfunction

	assign out_load = valid_s1 && (!out_valid_q || out_ready);
	assign s1_free  = !valid_s1 || out_load;
	assign pop      = ev_valid && (!ev.last || s1_free);

	// Only the first ending of a beat can differ from the first kind: a second
	// ending is always a lone CR that follows a lone CR.
	always_comb begin
		crlf_d  = sat_add(crlf_q, {1'b0, ev.k0_valid && ev.k0_kind == KIND_CRLF});
		lf_d    = sat_add(lf_q, {1'b0, ev.k0_valid && ev.k0_kind == KIND_LF});
		cr_d    = sat_add(cr_q, 2'(ev.k0_valid && ev.k0_kind == KIND_CR) + 2'(ev.k1_valid));
		end_d   = sat_add(end_q, 2'(ev.k0_valid) + 2'(ev.k1_valid));
		first_d = first_q;
		seen_d  = seen_q;
		mixed_d = mixed_q;
		mline_d = mline_q;
		if (ev.k0_valid) begin
			if (!seen_q) begin
				first_d = ev.k0_kind;
				seen_d  = 1'b1;
			end else if (ev.k0_kind != first_q && !mixed_q) begin
				mixed_d = 1'b1;
				mline_d = sat_add(end_q, 2'd1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crlf_q  <= '0;
			lf_q    <= '0;
			cr_q    <= '0;
			end_q   <= '0;
			mline_q <= '0;
			first_q <= KIND_LF;
			seen_q  <= 1'b0;
			mixed_q <= 1'b0;
		end else if (pop) begin
			if (ev.last) begin
				crlf_q  <= '0;
				lf_q    <= '0;
				cr_q    <= '0;
				end_q   <= '0;
				mline_q <= '0;
				first_q <= KIND_LF;
				seen_q  <= 1'b0;
				mixed_q <= 1'b0;
			end else begin
				crlf_q  <= crlf_d;
				lf_q    <= lf_d;
				cr_q    <= cr_d;
				end_q   <= end_d;
				mline_q <= mline_d;
				first_q <= first_d;
				seen_q  <= seen_d;
				mixed_q <= mixed_d;
			end
		end
	end

	// Snapshot of a finished stream, waiting for the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pop && ev.last) begin
			valid_s1 <= 1'b1;
		end else if (out_load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && ev.last) begin
			crlf_s1  <= crlf_d;
			lf_s1    <= lf_d;
			cr_s1    <= cr_d;
			mline_s1 <= mline_d;
			seen_s1  <= seen_d;
			mixed_s1 <= mixed_d;
		end
	end

	always_comb begin
		priority if (!seen_s1) begin
			dom = KIND_LF;
		end else if (crlf_s1 >= lf_s1 && crlf_s1 >= cr_s1) begin
			dom = KIND_CRLF;
		end else if (cr_s1 > lf_s1) begin
			dom = KIND_CR;
		end else begin
			dom = KIND_LF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {4'b0, clamp32(cr_s1), clamp32(lf_s1), clamp32(crlf_s1),
				clamp32(mline_s1), mixed_s1, dom, seen_s1};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop && ev.last |=> end_q == '0 && !seen_q && !mixed_q)
		else $error("stream state not cleared after the final beat");

	a_mixed_needs_seen: assert property (@(posedge clk) disable iff (!arst_n)
		mixed_q |-> seen_q && mline_q != '0)
		else $error("mix flagged without a recorded ending");

	a_snapshot_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_load |=> valid_s1 && $stable(crlf_s1) && $stable(mline_s1))
		else $error("finished stream lost while the output stalled");

endmodule

/* rtl/newline_convention_scanner.sv */
// Channel  Dir  Beat holds
// s_*      in   tdata[7:0] data_byte, tlast last_byte
// m_*      out  one summary per stream, fields packed in tdata (see port list)
//
// One byte is accepted every cycle while the event queue has room; each byte
// costs one pass through the counter update in the back end.
// After the final byte is accepted, the summary passes through the event queue,
// the snapshot stage and the output register before it appears on m_*.
// Reset clears the held CR, the queue, all counters and both valid flags.
// A stall on m_* first fills the snapshot stage, then the queue, then drops s_tready.
module newline_convention_scanner import nlcs_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,  // [7:0] data_byte
	input  logic                s_tlast,  // last_byte
	output logic                m_tvalid,
	input  logic                m_tready,
	// [0] found_any, [2:1] dominant_kind, [3] is_mixed, [35:4] first_mixed_line,
	// [67:36] crlf_total, [99:68] lf_total, [131:100] cr_total, [135:132] zero
	output logic [OUT_BITS-1:0] m_tdata
);

	logic        q_full, push, pop, head_valid;
	ending_evt_t push_evt, head_evt;

	nlcs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_byte  (s_tdata),
		.in_last  (s_tlast),
		.q_full   (q_full),
		.in_ready (s_tready),
		.push     (push),
		.push_evt (push_evt)
	);

	nlcs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_evt   (push_evt),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_evt   (head_evt)
	);

	nlcs_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ev_valid  (head_valid),
		.ev        (head_evt),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

/* test/newline_convention_scanner_tb.sv */
module newline_convention_scanner_tb;
	import nlcs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int BYTE_TARGET = 1700;

	typedef struct {
		logic [7:0] b;
		logic       fin;
		bit         drain;
	} text_byte_t;

	typedef struct {
		logic        found;
		kind_t       dom;
		logic        mixed;
		logic [31:0] mix_line;
		logic [31:0] crlf;
		logic [31:0] lf;
		logic [31:0] cr;
	} line_summary_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata = 8'h00;
	logic                s_tlast = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_BITS-1:0] m_tdata;

	text_byte_t    byte_q[$];
	line_summary_t summary_q[$];
	int            errors = 0;

	// Scanner state kept on the testbench side.
	logic        held_cr = 1'b0;
	logic [31:0] n_crlf = '0;
	logic [31:0] n_lf = '0;
	logic [31:0] n_cr = '0;
	logic [31:0] n_endings = '0;
	kind_t       first_seen = KIND_LF;
	logic        got_ending = 1'b0;
	logic        mix_seen = 1'b0;
	logic [31:0] mix_ordinal = '0;

	int burst_left = 1;
	int gap_left = 0;
	int sent = 0;
	bit gaps_on = 1'b1;
	int cycles = 0;
	int rx_mode = 0;

	newline_convention_scanner DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic [31:0] bump(logic [31:0] v);
		return (&v) ? v : v + 32'd1;
	endfunction

	task automatic note_ending(kind_t k);
		n_endings = bump(n_endings);
		case (k)
			KIND_CRLF: n_crlf = bump(n_crlf);
			KIND_CR:   n_cr = bump(n_cr);
			default:   n_lf = bump(n_lf);
		endcase
		if (!got_ending) begin
			first_seen = k;
			got_ending = 1'b1;
		end else if (k != first_seen && !mix_seen) begin
			mix_seen = 1'b1;
			mix_ordinal = n_endings;
		end
	endtask

	task automatic scan_byte(logic [7:0] b, logic fin);
		logic          used;
		line_summary_t s;
		used = 1'b0;
		if (held_cr) begin
			held_cr = 1'b0;
			if (b == BYTE_LF) begin
				note_ending(KIND_CRLF);
				used = 1'b1;
			end else begin
				note_ending(KIND_CR);
			end
		end
		if (!used) begin
			if (b == BYTE_CR)
				held_cr = 1'b1;
			else if (b == BYTE_LF)
				note_ending(KIND_LF);
		end
		if (fin) begin
			// A CR still held on the final byte can no longer pair up.
			if (held_cr) begin
				held_cr = 1'b0;
				note_ending(KIND_CR);
			end
			s.found = got_ending;
			s.dom = KIND_LF;
			if (got_ending) begin
				if (n_crlf >= n_lf && n_crlf >= n_cr)
					s.dom = KIND_CRLF;
				else if (n_cr > n_lf)
					s.dom = KIND_CR;
			end
			s.mixed = mix_seen;
			s.mix_line = mix_ordinal;
			s.crlf = n_crlf;
			s.lf = n_lf;
			s.cr = n_cr;
			summary_q.push_back(s);
			n_crlf = '0;
			n_lf = '0;
			n_cr = '0;
			n_endings = '0;
			first_seen = KIND_LF;
			got_ending = 1'b0;
			mix_seen = 1'b0;
			mix_ordinal = '0;
		end
	endtask

	function automatic bit field_ok(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	// In directed text, C stands for CR and L for LF.
	task automatic add_text(string txt);
		logic [7:0] b;
		for (int i = 0; i < txt.len(); i++) begin
			b = txt[i];
			if (b == "C")
				b = BYTE_CR;
			else if (b == "L")
				b = BYTE_LF;
			byte_q.push_back('{b, i == txt.len() - 1, 1'b0});
		end
	endtask

	initial begin
		int         len;
		int         cr_w;
		int         lf_w;
		int         r;
		int         stream_no;
		logic [7:0] b;

		byte_q.push_back('{8'h00, 1'b1, 1'b0});
		byte_q.push_back('{8'hFF, 1'b1, 1'b0});
		add_text("C");
		add_text("L");
		add_text("CL");
		add_text("CC");
		add_text("LC");
		add_text("aCLbL");
		add_text("CxLCL");
		add_text("CCL");

		stream_no = 0;
		while (byte_q.size() < BYTE_TARGET) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
			cr_w = $urandom_range(0, 4);
			lf_w = $urandom_range(0, 4);
			for (int i = 0; i < len; i++) begin
				r = $urandom_range(0, 9);
				if (r < cr_w)
					b = BYTE_CR;
				else if (r < cr_w + lf_w)
					b = BYTE_LF;
				else
					b = 8'($urandom_range(0, 255));
				byte_q.push_back('{b, i == len - 1, i == 0 && stream_no % 40 == 0});
			end
			stream_no++;
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (byte_q.size() != 0)
			@(posedge clk);
		// Let the monitor record the final beat before checking what is left.
		repeat (2) @(posedge clk);
		while (summary_q.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);

		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Sender: bursts of random length, with gap phases and gap-free phases.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				void'(byte_q.pop_front());
				sent++;
				if (sent % 250 == 0)
					gaps_on = $urandom_range(0, 2) != 0;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left = gaps_on ? $urandom_range(0, 7) : 0;
				end
			end
			if (s_tvalid && !s_tready) begin
				// Beat not taken yet: hold it.
			end else if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (byte_q.size() == 0 ||
					(byte_q[0].drain && (s_tvalid || summary_q.size() != 0))) begin
				// A marked stream waits until every summary so far is out.
				s_tvalid <= 1'b0;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata <= byte_q[0].b;
				s_tlast <= byte_q[0].fin;
			end
		end
	end

	// Receiver stall pattern and run limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			if (cycles % 300 == 0)
				rx_mode = $urandom_range(0, 3);
			case (rx_mode)
				0:       m_tready <= 1'b1;
				1:       m_tready <= $urandom_range(0, 3) != 0;
				2:       m_tready <= (cycles % 23) < 5;
				default: m_tready <= $urandom_range(0, 7) == 0;
			endcase
		end
	end

	always @(posedge clk) begin
		line_summary_t want;
		bit            ok;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				scan_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				if (summary_q.size() == 0) begin
					$display("%0t: summary beat with none expected, got %h", $time, m_tdata);
					errors++;
				end else begin
					want = summary_q.pop_front();
					ok = field_ok("found_any", 32'(want.found), 32'(m_tdata[0]))
						& field_ok("dominant_kind", 32'(want.dom), 32'(m_tdata[2:1]))
						& field_ok("is_mixed", 32'(want.mixed), 32'(m_tdata[3]))
						& field_ok("first_mixed_line", want.mix_line, m_tdata[35:4])
						& field_ok("crlf_total", want.crlf, m_tdata[67:36])
						& field_ok("lf_total", want.lf, m_tdata[99:68])
						& field_ok("cr_total", want.cr, m_tdata[131:100]);
					if (!ok)
						errors++;
				end
			end
		end
	end

endmodule
